FILE: rtl/mts_pkg.sv
// Shared types and constants for the min-tracking stack.
// Holds the item structs, the operation and error codes, and the cell control struct.
// Depends on nothing.
`default_nettype none

package mts_pkg;

	localparam int DATA_W = 32;
	localparam int DIFF_W = DATA_W + 1;
	localparam int FILL_W = 7;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_FULL  = 2'd1,
		ERR_EMPTY = 2'd2
	} err_t;

	typedef struct packed {
		op_t                      op;
		logic signed [DATA_W-1:0] push_value;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] top_value;
		logic signed [DATA_W-1:0] min_value;
		logic                     is_empty;
		logic [FILL_W-1:0]        fill_count;
		err_t                     error;
	} rsp_t;

	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/mts_cell.sv
// One stack cell: holds the stored difference of one stack level.
// Takes the neighbor above on a push and the neighbor below on a pop.
// Depends on mts_pkg.
`default_nettype none

module mts_cell #(
	parameter int W = 33
) (
	input  logic              clk,
	input  mts_pkg::cell_ctl_t ctl,
	input  logic [W-1:0]      from_above,
	input  logic [W-1:0]      from_below,
	output logic [W-1:0]      diff
);
	import mts_pkg::*;

	logic [W-1:0] diff_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			diff_q <= from_above;
		end else if (ctl.pop) begin
			diff_q <= from_below;
		end
	end

	assign diff = diff_q;

endmodule

`default_nettype wire

FILE: rtl/mts_out_buf.sv
// Two-entry result buffer that decouples the stack from the result channel.
// An output register plus a skid register; the block stalls only when both are full.
// Depends on mts_pkg.
`default_nettype none

module mts_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  mts_pkg::rsp_t wr_item,
	output logic          full,
	output logic          rd_valid,
	input  logic          rd_stall,
	output mts_pkg::rsp_t rd_item
);
	import mts_pkg::*;

	logic main_v_q, skid_v_q;
	rsp_t main_q, skid_q;
	logic take;
	logic main_v_mid, skid_v_mid;
	logic main_v_d, skid_v_d;
	logic load_main_from_skid, load_main_from_wr, load_skid_from_wr;

	assign take = main_v_q && !rd_stall;

	always_comb begin
		load_main_from_skid = take && skid_v_q;
		main_v_mid = take ? skid_v_q : main_v_q;
		skid_v_mid = take ? 1'b0 : skid_v_q;
		load_main_from_wr = wr && !main_v_mid;
		load_skid_from_wr = wr && main_v_mid;
		main_v_d = main_v_mid || wr;
		skid_v_d = skid_v_mid || load_skid_from_wr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			main_v_q <= main_v_d;
			skid_v_q <= skid_v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load_main_from_wr) begin
			main_q <= wr_item;
		end else if (load_main_from_skid) begin
			main_q <= skid_q;
		end
		if (load_skid_from_wr) begin
			skid_q <= wr_item;
		end
	end

	assign full = skid_v_q;
	assign rd_valid = main_v_q;
	assign rd_item = main_q;

endmodule

`default_nettype wire

FILE: rtl/min_tracking_stack_core.sv
// Top level of the min-tracking stack: control, minimum tracking and the cell chain.
// Depends on mts_pkg, mts_cell and mts_out_buf.
`default_nettype none

// The block is a signed stack of DEPTH entries that reports its top value and its
// minimum after every push or pop. Each command item yields exactly one result item,
// and one command is taken every clock cycle while the two-entry result buffer has room.
// The stack lives in a chain of DEPTH cells that all shift down on a push and up on a
// pop, so each level is a register with a two-way mux and the rate is one item per
// cycle while the buffer has room. Each cell stores the difference between its value
// and the minimum in force when it was pushed; a negative difference marks an entry
// that lowered the minimum. A push on a full stack and a pop on an empty one change
// nothing and are flagged in the error field. The fill count is reported in seven bits.
module min_tracking_stack_core #(
	parameter int DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  mts_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output mts_pkg::rsp_t rsp
);
	import mts_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]  count_q, count_d;
	logic [DATA_W-1:0] min_q, min_d;
	logic [DATA_W-1:0] top_q, top_d;
	logic [DIFF_W-1:0] diff_w [DEPTH+1];
	logic [DIFF_W-1:0] push_diff;
	logic              accept, is_full, is_empty_now;
	cell_ctl_t         ctl;
	rsp_t              rsp_d;

	logic [DATA_W-1:0] push_n, push_base;
	logic [DIFF_W-1:0] pop_min_ext;
	logic [DIFF_W-1:0] pop_top_ext;
	logic              buf_full;

	assign accept = cmd_valid && !cmd_stall;
	assign cmd_stall = buf_full;
	assign is_full = (count_q == CNT_W'(DEPTH));
	assign is_empty_now = (count_q == '0);
	assign diff_w[DEPTH] = '0;

	always_comb begin
		push_n = cmd.push_value;
		push_base = is_empty_now ? push_n : min_q;
		push_diff = {push_n[DATA_W-1], push_n} - {push_base[DATA_W-1], push_base};
		pop_min_ext = diff_w[0][DIFF_W-1] ? ({min_q[DATA_W-1], min_q} - diff_w[0])
		                                  : {min_q[DATA_W-1], min_q};
		pop_top_ext = pop_min_ext + diff_w[1];

		ctl = '0;
		count_d = count_q;
		min_d = min_q;
		top_d = top_q;
		rsp_d.error = ERR_NONE;

		if (cmd.op == OP_PUSH) begin
			if (is_full) begin
				rsp_d.error = ERR_FULL;
			end else begin
				ctl.push = accept;
				count_d = count_q + CNT_W'(1);
				min_d = push_diff[DIFF_W-1] ? push_n : push_base;
				top_d = push_n;
			end
		end else begin
			if (is_empty_now) begin
				rsp_d.error = ERR_EMPTY;
			end else begin
				ctl.pop = accept;
				count_d = count_q - CNT_W'(1);
				min_d = pop_min_ext[DATA_W-1:0];
				top_d = diff_w[1][DIFF_W-1] ? pop_min_ext[DATA_W-1:0]
				                            : pop_top_ext[DATA_W-1:0];
			end
		end

		rsp_d.is_empty = (count_d == '0);
		rsp_d.fill_count = FILL_W'(count_d);
		rsp_d.top_value = rsp_d.is_empty ? '0 : top_d;
		rsp_d.min_value = rsp_d.is_empty ? '0 : min_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			min_q <= '0;
			top_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
			min_q <= min_d;
			top_q <= top_d;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			mts_cell #(.W(DIFF_W)) u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.from_above (push_diff),
				.from_below (diff_w[1]),
				.diff       (diff_w[0])
			);
		end else begin : g_rest
			mts_cell #(.W(DIFF_W)) u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.from_above (diff_w[i-1]),
				.from_below (diff_w[i+1]),
				.diff       (diff_w[i])
			);
		end
	end

	mts_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (accept),
		.wr_item  (rsp_d),
		.full     (buf_full),
		.rd_valid (rsp_valid),
		.rd_stall (rsp_stall),
		.rd_item  (rsp)
	);

endmodule

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for min_tracking_stack_core: drives push and pop items,
// predicts each stack view (top, minimum, fill, error) and checks every result item.
// Depends on mts_pkg and the min_tracking_stack_core RTL.

module tb_top;

	import mts_pkg::*;

	localparam int STACK_DEPTH = 64;

	logic  clk = 1'b0;
	logic  arst_n;
	logic  cmd_valid;
	logic  cmd_stall;
	cmd_t  cmd;
	logic  rsp_valid;
	logic  rsp_stall;
	rsp_t  rsp;

	// Shadow copy of the stack: differences against the minimum at push time.
	logic [DIFF_W-1:0] shadow_diffs [STACK_DEPTH];
	int                shadow_fill;
	logic [DATA_W-1:0] shadow_min;

	rsp_t views_due [$];
	int   mismatch_count;
	bit   tx_gaps_on;
	bit   rsp_stalls_on;
	int   rsp_hold_cycles;

	min_tracking_stack_core #(
		.DEPTH(STACK_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic rsp_t apply_stack_op(input cmd_t c);
		rsp_t              view;
		logic [DIFF_W-1:0] d;
		err_t              e;
		e = ERR_NONE;
		if (c.op == OP_PUSH) begin
			if (shadow_fill >= STACK_DEPTH) begin
				e = ERR_FULL;
			end else begin
				if (shadow_fill == 0)
					shadow_min = c.push_value;
				d = {c.push_value[DATA_W-1], c.push_value} - {shadow_min[DATA_W-1], shadow_min};
				shadow_diffs[shadow_fill] = d;
				shadow_fill++;
				if (d[DIFF_W-1])
					shadow_min = c.push_value;
			end
		end else begin
			if (shadow_fill == 0) begin
				e = ERR_EMPTY;
			end else begin
				d = shadow_diffs[shadow_fill-1];
				if (d[DIFF_W-1])
					shadow_min = shadow_min - d[DATA_W-1:0];
				shadow_fill--;
			end
		end
		view = '0;
		view.error = e;
		view.fill_count = FILL_W'(shadow_fill);
		view.is_empty = (shadow_fill == 0);
		if (shadow_fill > 0) begin
			d = shadow_diffs[shadow_fill-1];
			view.min_value = shadow_min;
			view.top_value = d[DIFF_W-1] ? shadow_min : shadow_min + d[DATA_W-1:0];
		end
		return view;
	endfunction

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
		input logic [DATA_W-1:0] got);
		if (mismatch_count < 10)
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
		mismatch_count++;
	endtask

	// Records accepted commands first, then checks any result taken at the same edge.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && cmd_valid && !cmd_stall)
			views_due.insert(views_due.size(), apply_stack_op(cmd));
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (views_due.size() == 0) begin
				report_mismatch("unexpected result, top_value", '0, rsp.top_value);
			end else begin
				want = views_due.pop_front();
				if (rsp.top_value !== want.top_value)
					report_mismatch("top_value", want.top_value, rsp.top_value);
				if (rsp.min_value !== want.min_value)
					report_mismatch("min_value", want.min_value, rsp.min_value);
				if (rsp.is_empty !== want.is_empty)
					report_mismatch("is_empty", DATA_W'(want.is_empty),
						DATA_W'(rsp.is_empty));
				if (rsp.fill_count !== want.fill_count)
					report_mismatch("fill_count", DATA_W'(want.fill_count),
						DATA_W'(rsp.fill_count));
				if (rsp.error !== want.error)
					report_mismatch("error", DATA_W'(want.error), DATA_W'(rsp.error));
			end
		end
	end

	// Result side: random stall bursts, plus a long hold-off on request.
	initial begin
		int burst;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_hold_cycles > 0) begin
				rsp_stall <= 1'b1;
				repeat (rsp_hold_cycles) @(negedge clk);
				rsp_hold_cycles = 0;
				rsp_stall <= 1'b0;
			end else if (rsp_stalls_on && $urandom_range(0, 3) == 0) begin
				burst = $urandom_range(1, 10);
				rsp_stall <= 1'b1;
				repeat (burst) @(negedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	task automatic send_cmd(input op_t kind, input logic [DATA_W-1:0] value);
		int gap;
		gap = (tx_gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
		@(negedge clk);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= '{op: kind, push_value: value};
		do @(posedge clk); while (cmd_stall);
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 5))
			0: return DATA_W'($urandom_range(0, 15)) - DATA_W'(8);
			1: return {1'b0, {(DATA_W-1){1'b1}}};
			2: return {1'b1, {(DATA_W-1){1'b0}}};
			3: return shadow_min;
			default: return $urandom;
		endcase
	endfunction

	function automatic op_t pick_op(input int push_percent);
		return ($urandom_range(0, 99) < push_percent) ? OP_PUSH : OP_POP;
	endfunction

	task automatic test_directed_edges();
		logic [DATA_W-1:0] max_v;
		logic [DATA_W-1:0] min_v;
		max_v = {1'b0, {(DATA_W-1){1'b1}}};
		min_v = {1'b1, {(DATA_W-1){1'b0}}};
		send_cmd(OP_POP, $urandom);
		send_cmd(OP_PUSH, max_v);
		send_cmd(OP_PUSH, min_v);
		send_cmd(OP_PUSH, max_v);
		send_cmd(OP_PUSH, min_v);
		send_cmd(OP_PUSH, '0);
		send_cmd(OP_PUSH, '1);
		repeat (6) send_cmd(OP_POP, $urandom);
		send_cmd(OP_POP, '0);
		send_cmd(OP_PUSH, -DATA_W'(5));
		send_cmd(OP_PUSH, -DATA_W'(5));
		send_cmd(OP_PUSH, -DATA_W'(6));
		send_cmd(OP_PUSH, DATA_W'(1));
		repeat (4) send_cmd(OP_POP, '1);
		send_cmd(OP_POP, max_v);
	endtask

	task automatic test_full_stack();
		repeat (STACK_DEPTH + 2) send_cmd(OP_PUSH, pick_value());
		repeat (STACK_DEPTH + 2) send_cmd(OP_POP, $urandom);
	endtask

	task automatic test_backpressure();
		rsp_hold_cycles = 300;
		repeat (40) send_cmd(pick_op(70), pick_value());
	endtask

	task automatic test_random_ops(input int item_total);
		int sent;
		int run;
		int push_percent;
		sent = 0;
		while (sent < item_total) begin
			run = $urandom_range(10, 60);
			case ($urandom_range(0, 2))
				0: push_percent = 20;
				1: push_percent = 50;
				default: push_percent = 85;
			endcase
			repeat (run) send_cmd(pick_op(push_percent), pick_value());
			sent += run;
		end
	endtask

	initial begin
		int guard;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		tx_gaps_on = 1'b1;
		rsp_stalls_on = 1'b1;
		rsp_hold_cycles = 0;
		mismatch_count = 0;
		shadow_fill = 0;
		shadow_min = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_edges();
		test_full_stack();
		test_backpressure();
		test_random_ops(450);
		tx_gaps_on = 1'b0;
		rsp_stalls_on = 1'b0;
		test_random_ops(150);

		@(negedge clk);
		cmd_valid <= 1'b0;
		guard = 0;
		while (views_due.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
		if (views_due.size() != 0)
			$display("%0d expected results never arrived", views_due.size());
		if (mismatch_count == 0 && views_due.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/mts_pkg.sv
rtl/mts_cell.sv
rtl/mts_out_buf.sv
rtl/min_tracking_stack_core.sv
test/tb_top.sv
